>>> design/pee_pkg.sv
// pee_pkg: shared types, character codes, status codes and fixed-point
// helpers for the postfix expression evaluator; no dependencies
`timescale 1ns / 1ps

package pee_pkg;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_ADD  = 8'h2B;
  localparam logic [7:0] CH_SUB  = 8'h2D;
  localparam logic [7:0] CH_MUL  = 8'h2A;
  localparam logic [7:0] CH_DIV  = 8'h2F;
  localparam logic [7:0] CH_POW  = 8'h25;
  localparam logic [7:0] CH_END  = 8'h00;

  localparam logic [2:0] STS_OK      = 3'd0;
  localparam logic [2:0] STS_UNDER   = 3'd1;
  localparam logic [2:0] STS_OVER    = 3'd2;
  localparam logic [2:0] STS_ILLEGAL = 3'd3;
  localparam logic [2:0] STS_DIVZERO = 3'd4;

  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  localparam int unsigned DIV_STEPS = 48;

  typedef enum logic [2:0] {
    SYM_END, SYM_DIGIT, SYM_ADD, SYM_SUB, SYM_MUL, SYM_DIV, SYM_POW, SYM_ILL
  } sym_class_t;

  typedef enum logic [1:0] { RD_NONE, RD_T1, RD_T2 } rsel_t;
  typedef enum logic [1:0] { M_AB, M_RSQ, M_SQSQ } msel_t;
  typedef enum logic [1:0] { F_NONE, F_RES, F_R, F_SQ } mfin_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_CAPB, S_CAPA, S_EXEC, S_MULF_RES, S_DIV, S_DIVF,
    S_POW, S_MULF_R, S_POWSQ, S_MULF_SQ, S_POWEND, S_WRITE, S_TERM
  } state_t;

  typedef struct packed {
    logic       load_sym;
    logic       push;
    logic       note_en;
    logic [2:0] note_code;
    rsel_t      rd_sel;
    logic       cap_b;
    logic       cap_a;
    logic       alu;
    logic       mul_go;
    msel_t      mul_sel;
    mfin_t      mul_fin;
    logic       div_go;
    logic       div_one;
    logic       div_step;
    logic       div_fin;
    logic       pow_init;
    logic       pow_shift;
    logic       pow_end;
    logic       write_res;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    sym_class_t sym_class;
    logic       top_zero;
    logic       top_lt2;
    logic       top_full;
    logic       out_free;
    logic       m_zero;
    logic       m_odd;
    logic       m_more;
    logic       div_last;
    logic       pow_neg;
    logic       pow_ov;
  } status_t;

  typedef struct packed {
    logic               ov;
    logic signed [31:0] v;
  } sat_t;

  function automatic sym_class_t classify(input logic [7:0] sym);
    sym_class_t c;
    if (sym == CH_END) c = SYM_END;
    else if (sym >= CH_ZERO && sym <= CH_NINE) c = SYM_DIGIT;
    else if (sym == CH_ADD) c = SYM_ADD;
    else if (sym == CH_SUB) c = SYM_SUB;
    else if (sym == CH_MUL) c = SYM_MUL;
    else if (sym == CH_DIV) c = SYM_DIV;
    else if (sym == CH_POW) c = SYM_POW;
    else c = SYM_ILL;
    return c;
  endfunction

  // product scaled by 2^-16, truncated toward zero, then saturated
  function automatic sat_t mul_scale(input logic signed [63:0] p);
    logic signed [63:0] q;
    sat_t s;
    q = p >>> 16;
    if (p[63] && (p[15:0] != 16'd0)) q = q + 64'sd1;
    if (q > 64'sh0000_0000_7FFF_FFFF) begin
      s.ov = 1'b1;
      s.v  = Q_MAX;
    end else if (q < -64'sh0000_0000_8000_0000) begin
      s.ov = 1'b1;
      s.v  = Q_MIN;
    end else begin
      s.ov = 1'b0;
      s.v  = q[31:0];
    end
    return s;
  endfunction

endpackage

>>> design/pee_ram.sv
// pee_ram: generic single write port, single read port ram with a
// registered read; no dependencies
`timescale 1ns / 1ps

module pee_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/pee_ctrl.sv
// pee_ctrl: sequencing state machine of the evaluator
// depends on pee_pkg
`timescale 1ns / 1ps

module pee_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  pee_pkg::status_t st,
  output pee_pkg::cmd_t    cmd
);

  pee_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pee_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != pee_pkg::S_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pee_pkg::S_IDLE: if (in_valid) state_nxt = pee_pkg::S_DECODE;
      pee_pkg::S_DECODE: begin
        unique case (st.sym_class)
          pee_pkg::SYM_DIGIT: state_nxt = pee_pkg::S_IDLE;
          pee_pkg::SYM_END:
            state_nxt = st.top_zero ? pee_pkg::S_TERM : pee_pkg::S_CAPB;
          pee_pkg::SYM_ILL: state_nxt = pee_pkg::S_IDLE;
          default:
            state_nxt = st.top_lt2 ? pee_pkg::S_IDLE : pee_pkg::S_CAPB;
        endcase
      end
      pee_pkg::S_CAPB:
        state_nxt = (st.sym_class == pee_pkg::SYM_END) ? pee_pkg::S_TERM
                                                       : pee_pkg::S_CAPA;
      pee_pkg::S_CAPA: state_nxt = pee_pkg::S_EXEC;
      pee_pkg::S_EXEC: begin
        unique case (st.sym_class)
          pee_pkg::SYM_ADD, pee_pkg::SYM_SUB: state_nxt = pee_pkg::S_WRITE;
          pee_pkg::SYM_MUL: state_nxt = pee_pkg::S_MULF_RES;
          pee_pkg::SYM_DIV: state_nxt = pee_pkg::S_DIV;
          pee_pkg::SYM_POW: state_nxt = pee_pkg::S_POW;
          default: state_nxt = pee_pkg::S_IDLE;
        endcase
      end
      pee_pkg::S_MULF_RES: state_nxt = pee_pkg::S_WRITE;
      pee_pkg::S_DIV: if (st.div_last) state_nxt = pee_pkg::S_DIVF;
      pee_pkg::S_DIVF: state_nxt = pee_pkg::S_WRITE;
      pee_pkg::S_POW: begin
        priority if (st.m_zero) state_nxt = pee_pkg::S_POWEND;
        else if (st.m_odd) state_nxt = pee_pkg::S_MULF_R;
        else state_nxt = pee_pkg::S_POWSQ;
      end
      pee_pkg::S_MULF_R: state_nxt = pee_pkg::S_POWSQ;
      pee_pkg::S_POWSQ:
        state_nxt = st.m_more ? pee_pkg::S_MULF_SQ : pee_pkg::S_POW;
      pee_pkg::S_MULF_SQ: state_nxt = pee_pkg::S_POW;
      pee_pkg::S_POWEND:
        state_nxt = (st.pow_neg && !st.pow_ov) ? pee_pkg::S_DIV : pee_pkg::S_WRITE;
      pee_pkg::S_WRITE: state_nxt = pee_pkg::S_IDLE;
      pee_pkg::S_TERM: if (st.out_free) state_nxt = pee_pkg::S_IDLE;
      default: state_nxt = pee_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    unique case (state_r)
      pee_pkg::S_IDLE: cmd.load_sym = in_valid;
      pee_pkg::S_DECODE: begin
        unique case (st.sym_class)
          pee_pkg::SYM_DIGIT: begin
            if (st.top_full) begin
              cmd.note_en   = 1'b1;
              cmd.note_code = pee_pkg::STS_OVER;
            end else begin
              cmd.push = 1'b1;
            end
          end
          pee_pkg::SYM_END: if (!st.top_zero) cmd.rd_sel = pee_pkg::RD_T1;
          default: begin
            if (st.top_lt2) begin
              cmd.note_en   = 1'b1;
              cmd.note_code = pee_pkg::STS_UNDER;
            end else if (st.sym_class == pee_pkg::SYM_ILL) begin
              cmd.note_en   = 1'b1;
              cmd.note_code = pee_pkg::STS_ILLEGAL;
            end else begin
              cmd.rd_sel = pee_pkg::RD_T1;
            end
          end
        endcase
      end
      pee_pkg::S_CAPB: begin
        cmd.cap_b = 1'b1;
        if (st.sym_class != pee_pkg::SYM_END) cmd.rd_sel = pee_pkg::RD_T2;
      end
      pee_pkg::S_CAPA: cmd.cap_a = 1'b1;
      pee_pkg::S_EXEC: begin
        unique case (st.sym_class)
          pee_pkg::SYM_ADD, pee_pkg::SYM_SUB: cmd.alu = 1'b1;
          pee_pkg::SYM_MUL: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = pee_pkg::M_AB;
          end
          pee_pkg::SYM_DIV: cmd.div_go = 1'b1;
          pee_pkg::SYM_POW: cmd.pow_init = 1'b1;
          default: ;
        endcase
      end
      pee_pkg::S_MULF_RES: cmd.mul_fin = pee_pkg::F_RES;
      pee_pkg::S_DIV: cmd.div_step = 1'b1;
      pee_pkg::S_DIVF: cmd.div_fin = 1'b1;
      pee_pkg::S_POW: begin
        if (!st.m_zero && st.m_odd) begin
          cmd.mul_go  = 1'b1;
          cmd.mul_sel = pee_pkg::M_RSQ;
        end
      end
      pee_pkg::S_MULF_R: cmd.mul_fin = pee_pkg::F_R;
      pee_pkg::S_POWSQ: begin
        cmd.pow_shift = 1'b1;
        if (st.m_more) begin
          cmd.mul_go  = 1'b1;
          cmd.mul_sel = pee_pkg::M_SQSQ;
        end
      end
      pee_pkg::S_MULF_SQ: cmd.mul_fin = pee_pkg::F_SQ;
      pee_pkg::S_POWEND: begin
        cmd.pow_end = 1'b1;
        if (st.pow_neg && !st.pow_ov) begin
          cmd.div_go  = 1'b1;
          cmd.div_one = 1'b1;
        end
      end
      pee_pkg::S_WRITE: cmd.write_res = 1'b1;
      pee_pkg::S_TERM: cmd.emit = st.out_free;
      default: ;
    endcase
  end

endmodule

>>> design/pee_dp.sv
// pee_dp: stack memory, stack pointer, error hold, adder, multiplier,
// radix-2 divider, power registers and output register; depends on
// pee_pkg and pee_ram
`timescale 1ns / 1ps

module pee_dp #(
  parameter int STACK_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pee_pkg::cmd_t      cmd,
  output pee_pkg::status_t   st,
  input  logic [7:0]         in_symbol,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_value,
  output logic [2:0]         out_status
);

  localparam int TW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(pee_pkg::DIV_STEPS);

  logic [7:0]         sym_r;
  logic [TW-1:0]      top_r;
  logic [2:0]         err_r;
  logic signed [31:0] a_r, b_r, res_r, r_r, sq_r;
  logic signed [63:0] pr_r;
  logic [15:0]        m_r;
  logic               pneg_r, pov_r;
  logic [32:0]        rem_r;
  logic [47:0]        quo_r;
  logic [31:0]        dv_r;
  logic [CW-1:0]      cnt_r;
  logic               qneg_r, dz_r, dvd_neg_r, dvd_zero_r;
  logic               out_valid_r;
  logic signed [31:0] out_value_r;
  logic [2:0]         out_status_r;

  pee_pkg::sym_class_t sym_class;
  logic [TW-1:0]       top_m1, top_m2;
  logic [AW-1:0]       raddr, waddr;
  logic [31:0]         rdata, wdata;
  logic                we;

  assign sym_class = pee_pkg::classify(sym_r);
  assign top_m1    = top_r - TW'(1);
  assign top_m2    = top_r - TW'(2);
  assign raddr     = (cmd.rd_sel == pee_pkg::RD_T2) ? top_m2[AW-1:0] : top_m1[AW-1:0];
  assign waddr     = cmd.push ? top_r[AW-1:0] : top_m2[AW-1:0];
  assign we        = cmd.push | cmd.write_res;
  assign wdata     = cmd.push ? {12'd0, sym_r[3:0], 16'd0} : res_r;

  pee_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // add / subtract with saturation
  logic [32:0]   sum;
  pee_pkg::sat_t alu_s;
  always_comb begin
    if (sym_class == pee_pkg::SYM_SUB) sum = {a_r[31], a_r} - {b_r[31], b_r};
    else sum = {a_r[31], a_r} + {b_r[31], b_r};
    alu_s.ov = sum[32] ^ sum[31];
    alu_s.v  = alu_s.ov ? (sum[32] ? pee_pkg::Q_MIN : pee_pkg::Q_MAX) : sum[31:0];
  end

  // multiplier operand select, product registered, scaled next cycle
  logic signed [31:0] mx, my;
  pee_pkg::sat_t      mul_s;
  always_comb begin
    unique case (cmd.mul_sel)
      pee_pkg::M_RSQ: begin
        mx = r_r;
        my = sq_r;
      end
      pee_pkg::M_SQSQ: begin
        mx = sq_r;
        my = sq_r;
      end
      default: begin
        mx = a_r;
        my = b_r;
      end
    endcase
  end
  assign mul_s = pee_pkg::mul_scale(pr_r);

  // divider start operands and one restoring step
  logic signed [31:0] dx, dy;
  logic [31:0]        dx_mag, dy_mag;
  logic [32:0]        rs;
  logic               ge;
  assign dx     = cmd.div_one ? pee_pkg::Q_ONE : a_r;
  assign dy     = cmd.div_one ? r_r : b_r;
  assign dx_mag = dx[31] ? (32'd0 - dx) : dx;
  assign dy_mag = dy[31] ? (32'd0 - dy) : dy;
  assign rs     = {rem_r[31:0], quo_r[47]};
  assign ge     = (rs >= {1'b0, dv_r});

  pee_pkg::sat_t div_s;
  logic [2:0]    div_err;
  always_comb begin
    div_err = pee_pkg::STS_OK;
    if (dz_r) begin
      div_err  = pee_pkg::STS_DIVZERO;
      div_s.ov = 1'b0;
      div_s.v  = dvd_neg_r ? pee_pkg::Q_MIN : (dvd_zero_r ? 32'sd0 : pee_pkg::Q_MAX);
    end else if (qneg_r) begin
      div_s.ov = (quo_r > 48'h0000_8000_0000);
      div_s.v  = div_s.ov ? pee_pkg::Q_MIN : (32'd0 - quo_r[31:0]);
    end else begin
      div_s.ov = (quo_r > 48'h0000_7FFF_FFFF);
      div_s.v  = div_s.ov ? pee_pkg::Q_MAX : quo_r[31:0];
    end
    if (div_s.ov) div_err = pee_pkg::STS_OVER;
  end

  // integer part of the exponent, truncated toward zero
  logic signed [16:0] n_int, n_abs;
  always_comb begin
    n_int = {b_r[31], b_r[31:16]};
    if (b_r[31] && (b_r[15:0] != 16'd0)) n_int = n_int + 17'sd1;
    n_abs = n_int[16] ? -n_int : n_int;
  end

  // first error wins
  logic       note;
  logic [2:0] note_code;
  always_comb begin
    note      = 1'b0;
    note_code = pee_pkg::STS_OK;
    priority if (cmd.note_en) begin
      note      = 1'b1;
      note_code = cmd.note_code;
    end else if (cmd.alu && alu_s.ov) begin
      note      = 1'b1;
      note_code = pee_pkg::STS_OVER;
    end else if (cmd.mul_fin == pee_pkg::F_RES && mul_s.ov) begin
      note      = 1'b1;
      note_code = pee_pkg::STS_OVER;
    end else if (cmd.div_fin && div_err != pee_pkg::STS_OK) begin
      note      = 1'b1;
      note_code = div_err;
    end else if (cmd.pow_end && !pneg_r && pov_r) begin
      note      = 1'b1;
      note_code = pee_pkg::STS_OVER;
    end else begin
      note = 1'b0;
    end
  end

  logic [2:0] err_nxt;
  logic [TW-1:0] top_nxt;
  always_comb begin
    err_nxt = err_r;
    if (cmd.emit) err_nxt = pee_pkg::STS_OK;
    else if (note && err_r == pee_pkg::STS_OK) err_nxt = note_code;
    top_nxt = top_r;
    priority if (cmd.emit) top_nxt = '0;
    else if (cmd.push) top_nxt = top_r + TW'(1);
    else if (cmd.write_res) top_nxt = top_m1;
    else top_nxt = top_r;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r       <= '0;
      err_r       <= pee_pkg::STS_OK;
      out_valid_r <= 1'b0;
    end else begin
      top_r <= top_nxt;
      err_r <= err_nxt;
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_sym) sym_r <= in_symbol;
    if (cmd.cap_b) b_r <= rdata;
    if (cmd.cap_a) a_r <= rdata;
    if (cmd.alu) res_r <= alu_s.v;
    if (cmd.mul_go) pr_r <= mx * my;
    unique case (cmd.mul_fin)
      pee_pkg::F_RES: res_r <= mul_s.v;
      pee_pkg::F_R: begin
        r_r   <= mul_s.v;
        pov_r <= pov_r | mul_s.ov;
      end
      pee_pkg::F_SQ: begin
        sq_r  <= mul_s.v;
        pov_r <= pov_r | mul_s.ov;
      end
      default: ;
    endcase
    if (cmd.div_go) begin
      quo_r      <= {dx_mag, 16'd0};
      dv_r       <= dy_mag;
      rem_r      <= '0;
      cnt_r      <= '0;
      qneg_r     <= dx[31] ^ dy[31];
      dz_r       <= (dy == 32'sd0);
      dvd_neg_r  <= dx[31];
      dvd_zero_r <= (dx == 32'sd0);
    end else if (cmd.div_step) begin
      rem_r <= ge ? (rs - {1'b0, dv_r}) : rs;
      quo_r <= {quo_r[46:0], ge};
      cnt_r <= cnt_r + CW'(1);
    end
    if (cmd.div_fin) res_r <= div_s.v;
    if (cmd.pow_init) begin
      r_r    <= pee_pkg::Q_ONE;
      sq_r   <= a_r;
      pov_r  <= 1'b0;
      m_r    <= n_abs[15:0];
      pneg_r <= n_int[16];
    end else if (cmd.pow_shift) begin
      m_r <= {1'b0, m_r[15:1]};
    end
    if (cmd.pow_end && !(pneg_r && !pov_r)) res_r <= pneg_r ? 32'sd0 : r_r;
    if (cmd.emit) begin
      out_value_r  <= (top_r == '0) ? 32'sd0 : b_r;
      out_status_r <= (err_r != pee_pkg::STS_OK) ? err_r :
                      ((top_r == '0) ? pee_pkg::STS_UNDER : pee_pkg::STS_OK);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  assign st.sym_class = sym_class;
  assign st.top_zero  = (top_r == '0);
  assign st.top_lt2   = (top_r < TW'(2));
  assign st.top_full  = (top_r >= TW'(STACK_DEPTH));
  assign st.out_free  = !out_valid_r || !out_stall;
  assign st.m_zero    = (m_r == 16'd0);
  assign st.m_odd     = m_r[0];
  assign st.m_more    = (m_r[15:1] != 15'd0);
  assign st.div_last  = (cnt_r == CW'(pee_pkg::DIV_STEPS - 1));
  assign st.pow_neg   = pneg_r;
  assign st.pow_ov    = pov_r;

endmodule

>>> design/postfix_expression_evaluator.sv
// channel  | ports                          | direction | moves
// input    | in_valid in_stall in_symbol    | in        | one character word
// result   | out_valid out_stall out_value  | out       | one result word
//          | out_status                     |           |
//
// one character word at a time, each taken only from idle: a digit, an illegal symbol or a
// short stack returns straight to idle, + and - use the adder, * the multiplier, / the 48 steps
// of the radix-2 divider; a power steps once per exponent bit, multiplying for each set bit
// and squaring between bits, then runs the divider for the reciprocal of a negative exponent
// a terminator hands its result to the output register; reset (rst_n low, synchronous) empties
// the stack and clears the held error; a finished result waits in the output register
// while new words are taken, and a terminator waits only if the previous result is stalled
`timescale 1ns / 1ps

module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_symbol,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_value,
  output logic [2:0]         out_status
);

  // command and status between sequencer and datapath
  pee_pkg::cmd_t    cmd;
  pee_pkg::status_t st;

  // sequencer: decodes the character, steps the multiplier, divider and
  // power loop, and hands the terminator result to the output register
  pee_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // datapath: operand stack in ram, arithmetic units, error hold
  pee_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_symbol  (in_symbol),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_value  (out_value),
    .out_status (out_status)
  );

`ifndef SYNTHESIS
  // a word is taken only from idle, so the next cycle is always busy
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("word accepted twice in a row");

  // a result is only loaded into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid || !out_stall))
    else $error("result overwrote a stalled result");

  // an emitted result shows on the output next cycle
  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid)
    else $error("emitted result not visible");

  // push and operator write never share the ram port
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.push && cmd.write_res))
    else $error("two stack writes in one cycle");
`endif

endmodule

>>> bench/tb_postfix_expression_evaluator.sv
// testbench for the postfix expression evaluator: drives character words,
// predicts results with a scoreboard class; depends on pee_pkg and the rtl
`timescale 1ns / 1ps

module tb_postfix_expression_evaluator;

  localparam int DEPTH = 64;

  class pee_scoreboard;
    logic signed [31:0] stk [DEPTH];
    int unsigned        top;
    logic [2:0]         held;
    logic signed [31:0] want_value [$];
    logic [2:0]         want_status [$];
    int                 mismatches;

    function void clear();
      top = 0;
      held = pee_pkg::STS_OK;
      mismatches = 0;
    endfunction

    function void note(input logic [2:0] code);
      if (held == pee_pkg::STS_OK) held = code;
    endfunction

    // clamp a wide value to q16.16 range
    function logic signed [31:0] clamp(input logic signed [63:0] v, inout bit ov);
      if (v > 64'sd2147483647) begin
        ov = 1;
        return pee_pkg::Q_MAX;
      end
      if (v < -64'sd2147483648) begin
        ov = 1;
        return pee_pkg::Q_MIN;
      end
      return v[31:0];
    endfunction

    function logic signed [31:0] qmul(input logic signed [31:0] a, b, inout bit ov);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b);
      return clamp(p / 64'sd65536, ov);
    endfunction

    function logic signed [31:0] qdiv(input logic signed [31:0] a, b);
      bit ov;
      logic signed [31:0] r;
      ov = 0;
      if (b == 0) begin
        note(pee_pkg::STS_DIVZERO);
        if (a > 0) return pee_pkg::Q_MAX;
        if (a < 0) return pee_pkg::Q_MIN;
        return 0;
      end
      r = clamp((64'(a) * 64'sd65536) / 64'(b), ov);
      if (ov) note(pee_pkg::STS_OVER);
      return r;
    endfunction

    // integer power by repeated squaring, reciprocal for negative exponent
    function logic signed [31:0] qpow(input logic signed [31:0] base, expo);
      int n;
      int unsigned m;
      logic signed [31:0] r, sq;
      bit ov;
      n = expo / 65536;
      m = (n < 0) ? -n : n;
      r = pee_pkg::Q_ONE;
      sq = base;
      ov = 0;
      while (m != 0) begin
        if (m[0]) r = qmul(r, sq, ov);
        m = m >> 1;
        if (m != 0) sq = qmul(sq, sq, ov);
      end
      if (n >= 0) begin
        if (ov) note(pee_pkg::STS_OVER);
        return r;
      end
      if (ov) return 0;
      return qdiv(pee_pkg::Q_ONE, r);
    endfunction

    function void accept(input logic [7:0] sym);
      logic signed [31:0] a, b, r;
      bit ov;
      pee_pkg::sym_class_t c;
      c = pee_pkg::classify(sym);
      ov = 0;
      if (c == pee_pkg::SYM_END) begin
        r = 0;
        if (top == 0) note(pee_pkg::STS_UNDER);
        else r = stk[top-1];
        want_value.push_back(r);
        want_status.push_back(held);
        top = 0;
        held = pee_pkg::STS_OK;
        return;
      end
      if (c == pee_pkg::SYM_DIGIT) begin
        if (top >= DEPTH) note(pee_pkg::STS_OVER);
        else begin
          stk[top] = 32'(sym - pee_pkg::CH_ZERO) <<< 16;
          top++;
        end
        return;
      end
      if (top < 2) begin
        note(pee_pkg::STS_UNDER);
        return;
      end
      if (c == pee_pkg::SYM_ILL) begin
        note(pee_pkg::STS_ILLEGAL);
        return;
      end
      b = stk[top-1];
      a = stk[top-2];
      case (c)
        pee_pkg::SYM_ADD: r = clamp(64'(a) + 64'(b), ov);
        pee_pkg::SYM_SUB: r = clamp(64'(a) - 64'(b), ov);
        pee_pkg::SYM_MUL: r = qmul(a, b, ov);
        pee_pkg::SYM_DIV: r = qdiv(a, b);
        default: r = qpow(a, b);
      endcase
      if (ov) note(pee_pkg::STS_OVER);
      stk[top-2] = r;
      top--;
    endfunction

    function void check(input logic signed [31:0] v, input logic [2:0] s);
      logic signed [31:0] ev;
      logic [2:0] es;
      if (want_value.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result value=%h status=%0d", v, s);
        return;
      end
      ev = want_value.pop_front();
      es = want_status.pop_front();
      if (ev !== v || es !== s) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected value=%h status=%0d, got value=%h status=%0d",
                   ev, es, v, s);
      end
    endfunction

    function int pending();
      return want_value.size();
    endfunction
  endclass

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_stall;
  logic [7:0]         in_symbol = '0;
  logic               out_valid;
  logic               out_stall = 0;
  logic signed [31:0] out_value;
  logic [2:0]         out_status;

  pee_scoreboard sb;
  int            sent_words;

  always #2 clk = ~clk;

  postfix_expression_evaluator #(.STACK_DEPTH(DEPTH)) dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_symbol,
    .out_valid, .out_stall, .out_value, .out_status
  );

  // send one character word, with a random gap beforehand; valid stays high
  // between words sent back to back
  task automatic send_word(input logic [7:0] sym, input bit gap = 1);
    int g;
    g = gap ? $urandom_range(0, 6) : 0;
    // stretches without gaps
    if ($urandom_range(0, 3) == 0) g = 0;
    @(negedge clk);
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1;
    in_symbol <= sym;
    do @(posedge clk); while (in_stall);
    sb.accept(sym);
    sent_words++;
  endtask

  // characters of one expression, then the terminator
  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i]);
    send_word(pee_pkg::CH_END);
  endtask

  // quiesce: wait for all predicted results, then a drain margin
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  function automatic logic [7:0] rand_digit();
    return pee_pkg::CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_op();
    case ($urandom_range(0, 4))
      0: return pee_pkg::CH_ADD;
      1: return pee_pkg::CH_SUB;
      2: return pee_pkg::CH_MUL;
      3: return pee_pkg::CH_DIV;
      default: return pee_pkg::CH_POW;
    endcase
  endfunction

  // well-formed expression with random content, occasionally broken
  task automatic send_expression();
    int depth, n;
    bit noisy;
    depth = 0;
    n = $urandom_range(1, 10);
    noisy = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < n; i++) begin
      if (depth < 2 || $urandom_range(0, 1)) begin
        send_word(rand_digit());
        depth++;
      end else begin
        send_word(rand_op());
        depth--;
      end
      // noise: any nonzero byte value
      if (noisy && $urandom_range(0, 3) == 0) send_word(8'($urandom_range(1, 255)));
    end
    while (depth > 1 && $urandom_range(0, 3) != 0) begin
      send_word(rand_op());
      depth--;
    end
    send_word(pee_pkg::CH_END);
  endtask

  // result side: each result is held off by a random stall, sampled at the rising edge
  initial begin
    int w_left;
    sb = new();
    sb.clear();
    w_left = $urandom_range(0, 6);
    forever begin
      @(negedge clk);
      out_stall <= out_valid && (w_left != 0);
      if (out_valid && w_left != 0) w_left--;
      @(posedge clk);
      if (out_valid && !out_stall) begin
        sb.check(out_value, out_status);
        w_left = $urandom_range(0, 6);
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed: every operator, extremes, special cases
    send_string("34+");
    send_string("92-");
    send_string("78*");
    send_string("71/");
    send_string("23%");
    send_word(pee_pkg::CH_END);        // empty terminator
    send_string("5+");                 // too few operands
    send_string("12!");                // illegal symbol with two entries
    send_string("50/");                // divide by zero, positive
    send_string("00/");                // zero over zero
    send_string("05-0/");              // negative dividend
    send_string("002-%");              // reciprocal of zero power
    send_string("99*9*9*9*");          // multiply saturation
    send_string("99%");                // power saturates
    send_string("9909-%");             // saturated power, negative exponent
    send_string("20%");                // zero exponent
    send_string("129-");               // leftover operands
    send_word(8'hFF);
    send_word(8'h80);
    send_word(pee_pkg::CH_END);
    // stack full: push past the depth
    for (int i = 0; i < DEPTH + 2; i++) send_word(rand_digit(), 0);
    send_word(pee_pkg::CH_END);

    // sender pause until every result has come
    wait_drained();

    while (sent_words < 900) begin
      send_expression();
      if ($urandom_range(0, 40) == 0) wait_drained();
    end
    wait_drained();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // timeout
  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
